// ----- hw/rtl/qef_pkg.sv -----
// shared types, constants and helpers for the q15 envelope follower
// no dependencies

package qef_pkg;

  localparam int unsigned LEVEL_W = 15;
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned COEF_W = 15;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [LEVEL_W-1:0] Q15_MAX_LEVEL = 15'h7fff;
  localparam logic [COEF_W-1:0] ATTACK_RESET = 15'h0000;
  localparam logic [COEF_W-1:0] RELEASE_RESET = 15'h7fff;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ATTACK_COEF  = 1'b0,
    CFG_RELEASE_COEF = 1'b1
  } cfg_reg_t;

  // rectify a signed q15 sample, most negative value saturates
  function automatic logic [LEVEL_W-1:0] q15_abs(input logic signed [SAMPLE_W-1:0] s);
    logic [SAMPLE_W-1:0] neg;
    begin
      neg = SAMPLE_W'(-s);
      if (s == 16'sh8000) begin
        return Q15_MAX_LEVEL;
      end else if (s[SAMPLE_W-1]) begin
        return neg[LEVEL_W-1:0];
      end else begin
        return s[LEVEL_W-1:0];
      end
    end
  endfunction

endpackage

// ----- hw/rtl/qef_update.sv -----
// envelope update datapath: coefficient select, q15 multiply, floor shift
// depends on qef_pkg

module qef_update import qef_pkg::*; (
  input  logic [LEVEL_W-1:0] envelope,
  input  logic [LEVEL_W-1:0] target,
  input  logic [COEF_W-1:0]  attack_coef,
  input  logic [COEF_W-1:0]  release_coef,
  output logic [LEVEL_W-1:0] envelope_next
);

  logic [COEF_W-1:0]  coef;
  logic signed [15:0] diff;
  logic signed [31:0] prod;
  logic signed [31:0] step;
  logic signed [17:0] sum;

  // attack while rising, release while falling or holding
  assign coef = (target > envelope) ? attack_coef : release_coef;

  // coef * (envelope - target), floor shift by 15
  assign diff = $signed({1'b0, envelope}) - $signed({1'b0, target});
  assign prod = $signed({1'b0, coef}) * diff;
  assign step = prod >>> 15;
  assign sum  = $signed({3'b000, target}) + $signed(step[17:0]);

  // clamp to the q15 level range
  always_comb begin
    if (sum[17]) begin
      envelope_next = '0;
    end else if (sum > $signed({3'b000, Q15_MAX_LEVEL})) begin
      envelope_next = Q15_MAX_LEVEL;
    end else begin
      envelope_next = sum[LEVEL_W-1:0];
    end
  end

endmodule

// ----- hw/rtl/q15_envelope_follower.sv -----
// top level of the q15 attack/release envelope follower
// depends on qef_pkg and qef_update

// Attack/release envelope follower on signed Q15 samples. Each sample is
// rectified (-32768 reads as 32767) and folded into a running block peak;
// a sample with in_block_end set closes the block, the peak becomes the
// target and one envelope result is produced, target + coef*(env-target)>>15
// with floor rounding. Samples without in_block_end produce no result. An
// item passes one input register and one result register: the result of a
// closing sample is registered once the result register is free, and one
// item can be taken every cycle while no result is held by out_stall; the
// update uses a single 16x16 multiply. A closing sample waits in the input
// register only while an earlier result is held by out_stall. Coefficients
// must be written over the cfg port while idle; the block does not check it.

module q15_envelope_follower import qef_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  // input sample channel
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  input  logic                       in_block_end,
  // result channel
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [LEVEL_W-1:0]         out_envelope,
  // configuration write channel
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [COEF_W-1:0]          cfg_data
);

  logic                       s1_valid_r, s1_valid_nxt;
  logic signed [SAMPLE_W-1:0] s1_sample_r;
  logic                       s1_end_r;
  logic                       out_valid_r, out_valid_nxt;
  logic [LEVEL_W-1:0]         out_envelope_r;
  logic [LEVEL_W-1:0]         envelope_level_r, envelope_level_nxt;
  logic [LEVEL_W-1:0]         block_peak_r, block_peak_nxt;
  logic [COEF_W-1:0]          attack_coef_r;
  logic [COEF_W-1:0]          release_coef_r;

  logic               out_free;
  logic               s1_go;
  logic               s1_emit;
  logic               in_xfer;
  logic [LEVEL_W-1:0] rect;
  logic [LEVEL_W-1:0] peak_now;
  logic [LEVEL_W-1:0] envelope_next;

  // handshake control
  assign out_free = !out_valid_r || !out_stall;
  assign s1_go    = s1_valid_r && (!s1_end_r || out_free);
  assign s1_emit  = s1_go && s1_end_r;
  assign in_stall = s1_valid_r && !s1_go;
  assign in_xfer  = in_valid && !in_stall;

  assign cfg_ready    = 1'b1;
  assign out_valid    = out_valid_r;
  assign out_envelope = out_envelope_r;

  // rectify and fold into the block peak
  assign rect     = q15_abs(s1_sample_r);
  assign peak_now = (rect > block_peak_r) ? rect : block_peak_r;

  qef_update u_update (
    .envelope      (envelope_level_r),
    .target        (peak_now),
    .attack_coef   (attack_coef_r),
    .release_coef  (release_coef_r),
    .envelope_next (envelope_next)
  );

  // next state
  always_comb begin
    s1_valid_nxt       = in_xfer || (s1_valid_r && !s1_go);
    block_peak_nxt     = block_peak_r;
    envelope_level_nxt = envelope_level_r;
    out_valid_nxt      = out_valid_r && out_stall;
    if (s1_go) begin
      if (s1_end_r) begin
        block_peak_nxt     = '0;
        envelope_level_nxt = envelope_next;
        out_valid_nxt      = 1'b1;
      end else begin
        block_peak_nxt = peak_now;
      end
    end
  end

  // control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r       <= 1'b0;
      out_valid_r      <= 1'b0;
      envelope_level_r <= '0;
      block_peak_r     <= '0;
      attack_coef_r    <= ATTACK_RESET;
      release_coef_r   <= RELEASE_RESET;
    end else begin
      s1_valid_r       <= s1_valid_nxt;
      out_valid_r      <= out_valid_nxt;
      envelope_level_r <= envelope_level_nxt;
      block_peak_r     <= block_peak_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          CFG_ATTACK_COEF:  attack_coef_r  <= cfg_data;
          CFG_RELEASE_COEF: release_coef_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_sample_r <= in_sample;
      s1_end_r    <= in_block_end;
    end
    if (s1_emit) begin
      out_envelope_r <= envelope_next;
    end
  end

`ifndef SYNTHESIS
  // a result only appears after a closing sample left the input register
  a_result_from_block_end: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_valid_r && s1_end_r))
    else $error("result without a closing sample");

  // the peak is cleared once a block closes
  a_peak_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    s1_emit |=> (block_peak_r == '0))
    else $error("block peak not cleared after block end");

  // a held result always matches the current envelope state
  a_result_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_envelope_r == envelope_level_r))
    else $error("held result differs from envelope state");

  // the peak never falls inside a block
  a_peak_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_go && !s1_end_r) |=> (block_peak_r >= $past(block_peak_r)))
    else $error("block peak decreased inside a block");
`endif

endmodule

// ----- tb/sv/qef_tb_pkg.sv -----
`timescale 1ns / 1ps
// scoreboard class for the q15 envelope follower testbench
// depends on qef_pkg for widths and register indexes

package qef_tb_pkg;
  import qef_pkg::*;

  class envelope_scoreboard;
    logic [COEF_W-1:0]  attack_coef;
    logic [COEF_W-1:0]  release_coef;
    logic [LEVEL_W-1:0] envelope_level;
    logic [LEVEL_W-1:0] block_peak;
    logic [LEVEL_W-1:0] envelope_q[$];
    int unsigned        mismatches;

    function new();
      attack_coef    = ATTACK_RESET;
      release_coef   = RELEASE_RESET;
      envelope_level = '0;
      block_peak     = '0;
      mismatches     = 0;
    endfunction

    // mirror of a coefficient register transfer
    function void write_coef(cfg_reg_t idx, logic [COEF_W-1:0] val);
      case (idx)
        CFG_ATTACK_COEF:  attack_coef = val;
        CFG_RELEASE_COEF: release_coef = val;
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return envelope_q.size();
    endfunction

    // one line per mismatch
    task flag_mismatch(string msg);
      $display("mismatch: %s", msg);
      mismatches++;
    endtask

    // accepted input sample: track the peak, update on block end
    function void note_sample(logic signed [SAMPLE_W-1:0] sample, logic block_end);
      int mag;
      int target;
      int level;
      int coef;
      int product;
      int next_level;
      mag = sample;
      if (mag < 0) begin
        mag = -mag;
      end
      if (mag > int'(Q15_MAX_LEVEL)) begin
        mag = int'(Q15_MAX_LEVEL);
      end
      if (mag > int'(block_peak)) begin
        block_peak = mag[LEVEL_W-1:0];
      end
      if (block_end) begin
        target = block_peak;
        level  = envelope_level;
        coef   = (target > level) ? int'(attack_coef) : int'(release_coef);
        // signed product, arithmetic shift rounds toward minus infinity
        product    = coef * (level - target);
        next_level = target + (product >>> 15);
        if (next_level < 0) begin
          next_level = 0;
        end
        if (next_level > int'(Q15_MAX_LEVEL)) begin
          next_level = int'(Q15_MAX_LEVEL);
        end
        envelope_level = next_level[LEVEL_W-1:0];
        block_peak     = '0;
        envelope_q.push_back(envelope_level);
      end
    endfunction

    // accepted result against the oldest pending envelope
    task check_envelope(logic [LEVEL_W-1:0] got);
      logic [LEVEL_W-1:0] want;
      if (envelope_q.size() == 0) begin
        flag_mismatch($sformatf("envelope %0d with no block pending", got));
      end else begin
        want = envelope_q.pop_front();
        if (got !== want) begin
          flag_mismatch($sformatf("envelope got %0d expected %0d", got, want));
        end
      end
    endtask
  endclass

endpackage

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
// top testbench for q15_envelope_follower: directed and random sample blocks,
// coefficient writes between phases, results checked by envelope_scoreboard
// depends on qef_pkg, qef_tb_pkg and the rtl of the block

module tb_top;
  import qef_pkg::*;
  import qef_tb_pkg::*;

  localparam int IDLE_CYCLES = 4;
  localparam int LONG_HOLD   = 150;
  localparam int DRAIN_LIMIT = 2000;

  logic                       clk;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_stall;
  logic signed [SAMPLE_W-1:0] in_sample;
  logic                       in_block_end;
  logic                       out_valid;
  logic                       out_stall;
  logic [LEVEL_W-1:0]         out_envelope;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic [CFG_IDX_W-1:0]       cfg_index;
  logic [COEF_W-1:0]          cfg_data;

  envelope_scoreboard sb = new();

  // shared between sender and receiver
  bit calm;
  bit hold_request;

  q15_envelope_follower u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_sample    (in_sample),
    .in_block_end (in_block_end),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_envelope (out_envelope),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop
  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // one sample transfer, with a random gap before it
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] s, input logic last);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_sample    <= s;
    in_block_end <= last;
    do @(posedge clk); while (in_stall);
    sb.note_sample(s, last);
  endtask

  // wait until every envelope has come back and the pipe is empty
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (IDLE_CYCLES) @(posedge clk);
  endtask

  // one register transfer on the cfg channel
  task automatic write_reg(input cfg_reg_t idx, input logic [COEF_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.write_coef(idx, val);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    int v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: v = $urandom_range(0, 65535);
      5, 6:          v = $urandom_range(0, 512) - 256;
      7: begin
        case ($urandom_range(0, 3))
          0:       v = -32768;
          1:       v = 32767;
          2:       v = 0;
          default: v = -1;
        endcase
      end
      default: begin
        // close to the current level so attack and release both show up
        v = int'(sb.envelope_level) + $urandom_range(0, 64) - 32;
        if ($urandom_range(0, 1)) begin
          v = -v;
        end
      end
    endcase
    return SAMPLE_W'(v);
  endfunction

  // one phase: coefficient writes, then random blocks
  task automatic run_phase(input logic [COEF_W-1:0] attack, input logic [COEF_W-1:0] rel,
                           input int n_items, input bit long_hold, input bit mid_pause);
    int sent;
    int len;
    wait_idle();
    write_reg(CFG_ATTACK_COEF, attack);
    write_reg(CFG_RELEASE_COEF, rel);
    sent = 0;
    if (long_hold) begin
      hold_request = 1'b1;
    end
    while (sent < n_items) begin
      calm = ((sent / 100) % 3) == 0;
      if (mid_pause && sent >= n_items / 2 && sent < n_items / 2 + 8) begin
        wait_idle();
      end
      case ($urandom_range(0, 9))
        0, 1:          len = 1;
        2, 3, 4, 5, 6: len = $urandom_range(2, 8);
        7:             len = $urandom_range(9, 40);
        default:       len = $urandom_range(1, 4);
      endcase
      for (int i = 0; i < len; i++) begin
        send_sample(pick_sample(), i == len - 1);
      end
      sent += len;
    end
    calm = 1'b0;
  endtask

  // result side: random stall per transfer, one long hold on request
  initial begin
    int gap;
    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_request) begin
        gap = LONG_HOLD;
        hold_request = 1'b0;
      end else begin
        gap = calm ? 0 : $urandom_range(0, 3);
      end
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
      sb.check_envelope(out_envelope);
    end
  end

  // stimulus
  initial begin
    int wait_cycles;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_sample    = '0;
    in_block_end = 1'b0;
    cfg_valid    = 1'b0;
    cfg_index    = CFG_ATTACK_COEF;
    cfg_data     = '0;
    calm         = 1'b0;
    hold_request = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: zero attack makes the envelope jump to the target
    write_reg(CFG_ATTACK_COEF, 15'd0);
    write_reg(CFG_RELEASE_COEF, 15'd16384);
    send_sample(16'sh8000, 1'b1);     // most negative rectifies to full scale
    send_sample(16'sh7fff, 1'b1);     // equal target and envelope holds
    send_sample(16'sh0000, 1'b1);     // release toward zero
    send_sample(-16'sd1, 1'b0);
    send_sample(16'sd1, 1'b0);
    send_sample(-16'sd32767, 1'b0);
    send_sample(16'sd100, 1'b1);      // closes a multi-sample block, peak 32767
    send_sample(16'sh0000, 1'b1);
    send_sample(-16'sd5, 1'b1);

    // directed: nonzero attack, negative product rounds down
    wait_idle();
    write_reg(CFG_ATTACK_COEF, 15'd12345);
    send_sample(16'sh0000, 1'b1);
    send_sample(16'sh7fff, 1'b1);
    send_sample(16'sh5555, 1'b1);
    send_sample(16'shaaaa, 1'b1);
    // long block without end, peak keeps the maximum
    for (int i = 0; i < 10; i++) begin
      send_sample(SAMPLE_W'(i * 1000 - 4000), 1'b0);
    end
    send_sample(16'sd7, 1'b1);

    // random phases across coefficient extremes
    run_phase(15'h7fff, 15'h0000, 305, 1'b0, 1'b0);
    run_phase(15'h0000, 15'h0000, 305, 1'b1, 1'b0);
    run_phase(15'h7fff, 15'h7fff, 305, 1'b0, 1'b1);
    run_phase(COEF_W'($urandom_range(0, 32767)), COEF_W'($urandom_range(0, 32767)),
              305, 1'b0, 1'b0);
    run_phase(COEF_W'($urandom_range(0, 4000)), COEF_W'($urandom_range(30000, 32767)),
              305, 1'b0, 1'b0);
    run_phase(ATTACK_RESET, RELEASE_RESET, 305, 1'b0, 1'b0);

    // drain and settle
    in_valid <= 1'b0;
    wait_cycles = 0;
    while (sb.pending() != 0 && wait_cycles < DRAIN_LIMIT) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (8) @(posedge clk);
    if (sb.pending() != 0) begin
      sb.flag_mismatch($sformatf("%0d envelopes never arrived", sb.pending()));
    end
    if (sb.mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
